@@ hdl/l1b_pkg.sv @@
// Package: shared types and state codes for the L1-ball projection block
package l1b_pkg;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               element_last;
  } l1b_in_t;

  typedef struct packed {
    logic signed [31:0] projected_value;
    logic               result_last;
  } l1b_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_ACC,
    ST_SCAN_CMP,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT
  } l1b_state_t;

endpackage

@@ hdl/l1_ball_projection.sv @@
// Top level: L1-ball projection of a streamed vector
// Elements are requested one at a time (start while busy is low). Each element is
// inserted by shifting every stored magnitude smaller than its own one place up,
// through the sorted store with its one write and one read port. The closing element
// adds the prefix scan, a restoring division for theta when the vector lies outside the
// ball, and then the results on out_valid, which cannot be stalled by the receiver.
module l1_ball_projection
  import l1b_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  l1b_in_t  in_data,
  output logic     out_valid,
  output l1b_out_t out_data,
  input  logic     cfg_we,
  input  logic [30:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  l1b_state_t st_r, st_nxt;
  logic [30:0]   rad_r;
  logic [31:0]   estore [MAX_LEN];
  logic [31:0]   sstore [MAX_LEN];
  logic [37:0]   pstore [MAX_LEN];
  logic [31:0]   e_rd_r, s_rd_r;
  logic [37:0]   p_rd_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic [37:0]   acc_r, acc_nxt;
  logic [37:0]   th_r, th_nxt;
  logic          close_r, close_nxt;
  logic          s_we, e_we, p_we;
  logic [AW-1:0] s_wa, s_ra, e_ra, p_ra;
  logic [31:0]   s_wd;
  logic [31:0]   in_mag;
  logic          div_start, div_done;
  logic [37:0]   div_num, div_q;
  logic [39:0]   lhs;
  logic signed [39:0] rhs, numv;
  logic signed [39:0] ev, pv;
  logic          out_v_r, out_v_nxt;
  l1b_out_t      out_r, out_nxt;

  assign in_mag = in_data.element_value[31] ? 32'(-in_data.element_value)
                                            : in_data.element_value;
  assign lhs  = 40'(s_rd_r) * 40'(i_r);
  assign rhs  = $signed({2'b00, acc_r}) - $signed({9'd0, rad_r});
  assign numv = $signed({2'b00, p_rd_r}) - $signed({9'd0, rad_r});
  assign ev   = 40'($signed(e_rd_r));
  assign div_num = numv[37:0];
  assign p_ra = (st_r == ST_SCAN_CMP) ? k_nxt : k_r;

  l1b_div #(.NW(38), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(CW'(k_r) + CW'(1)), .done(div_done), .quo(div_q)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (start) st_nxt = ST_INS_RD;
      ST_INS_RD:   st_nxt = (i_r == '0) ? ST_INS_CMP : ST_INS_CMP;
      ST_INS_CMP: begin
        if (i_r == '0 || s_rd_r >= mag_r)
          st_nxt = close_r ? ST_SCAN_RD : ST_IDLE;
        else
          st_nxt = ST_INS_RD;
      end
      ST_SCAN_RD:  st_nxt = ST_SCAN_ACC;
      ST_SCAN_ACC: st_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (i_r != n_r) st_nxt = ST_SCAN_RD;
        else if (acc_r <= 38'(rad_r)) st_nxt = ST_EMIT_RD;
        else st_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) st_nxt = ST_EMIT_RD;
      ST_EMIT_RD: st_nxt = ST_EMIT;
      ST_EMIT:    st_nxt = (i_r + CW'(1) == n_r) ? ST_IDLE : ST_EMIT_RD;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    n_nxt = n_r; i_nxt = i_r; k_nxt = k_r; mag_nxt = mag_r; acc_nxt = acc_r;
    th_nxt = th_r; close_nxt = close_r;
    s_we = 1'b0; e_we = 1'b0; p_we = 1'b0;
    s_wa = i_r[AW-1:0]; s_wd = mag_r;
    s_ra = AW'(i_r - CW'(1)); e_ra = i_r[AW-1:0];
    div_start = 1'b0; out_v_nxt = 1'b0; out_nxt = out_r;
    pv = '0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          e_we = 1'b1;
          mag_nxt = in_mag;
          i_nxt = n_r;
          n_nxt = n_r + CW'(1);
          close_nxt = in_data.element_last || (n_r == CW'(MAX_LEN - 1));
        end
      end
      ST_INS_CMP: begin
        if (i_r == '0 || s_rd_r >= mag_r) begin
          s_we = 1'b1;
          if (close_r) begin
            i_nxt = '0; acc_nxt = '0; k_nxt = '0; th_nxt = '0;
          end
        end else begin
          s_we = 1'b1;
          s_wd = s_rd_r;
          i_nxt = i_r - CW'(1);
        end
      end
      ST_SCAN_RD: s_ra = i_r[AW-1:0];
      ST_SCAN_ACC: begin
        s_ra = i_r[AW-1:0];
        acc_nxt = acc_r + 38'(s_rd_r);
        i_nxt = i_r + CW'(1);
      end
      ST_SCAN_CMP: begin
        p_we = 1'b1;
        s_wa = AW'(i_r - CW'(1));
        if ($signed({1'b0, lhs}) > $signed({rhs[39], rhs})) k_nxt = AW'(i_r - CW'(1));
        if (i_r == n_r) i_nxt = '0;
      end
      ST_DIV: begin
        s_wa = k_r;
        if (close_r) begin
          div_start = 1'b1;
          close_nxt = 1'b0;
        end
        if (div_done) th_nxt = (numv <= 0) ? '0 : div_q;
      end
      ST_EMIT: begin
        if (ev >= 0) begin
          pv = ev - $signed({2'b00, th_r});
          if (pv < 0) pv = '0;
        end else begin
          pv = ev + $signed({2'b00, th_r});
          if (pv > 0) pv = '0;
        end
        out_v_nxt = 1'b1;
        out_nxt.projected_value = pv[31:0];
        out_nxt.result_last = (i_r + CW'(1) == n_r);
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == n_r) n_nxt = '0;
      end
      default: ;
    endcase
  end

  // sorted store: single write port, single read port, registered read
  always_ff @(posedge clk) begin
    if (s_we) sstore[s_wa] <= s_wd;
    s_rd_r <= sstore[s_ra];
    if (e_we) estore[n_r[AW-1:0]] <= in_data.element_value;
    e_rd_r <= estore[e_ra];
    if (p_we) pstore[s_wa] <= acc_r;
    p_rd_r <= (p_we && s_wa == p_ra) ? acc_r : pstore[p_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rad_r <= 31'd65536;
      n_r <= '0; i_r <= '0; k_r <= '0; th_r <= '0; close_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) rad_r <= cfg_data;
      n_r <= n_nxt; i_r <= i_nxt; k_r <= k_nxt; th_r <= th_nxt;
      close_r <= close_nxt;
      out_v_r <= out_v_nxt;
    end
    mag_r <= mag_nxt;
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/l1b_div.sv @@
// Restoring divider: one quotient bit per cycle
module l1b_div
  import l1b_pkg::*;
#(
  parameter int NW = 38,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ sim/tb_l1_ball_projection.sv @@
// Testbench: L1-ball projection checked against a behavioural predictor
module tb_l1_ball_projection;
  import l1b_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 64;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  l1b_in_t     in_data;
  logic        out_valid;
  l1b_out_t    out_data;
  logic        cfg_we;
  logic [30:0] cfg_data;

  l1_ball_projection #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  logic signed [31:0] vec_elems[MAX_LEN];
  int                 vec_len;
  logic [30:0]        radius;
  l1b_out_t           projection_queue[$];
  int                 mismatches;
  int                 gap_pct;
  longint             cycles;

  function automatic logic [63:0] magnitude(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  task automatic predict_projection();
    logic [63:0]        mags[MAX_LEN];
    logic [63:0]        tmp;
    logic signed [63:0] acc, num, theta, v, p;
    logic signed [63:0] prefix[MAX_LEN];
    int                 k;
    l1b_out_t           r;
    for (int i = 0; i < vec_len; i++) mags[i] = magnitude(vec_elems[i]);
    for (int i = 1; i < vec_len; i++)
      for (int j = i; j > 0 && mags[j-1] < mags[j]; j--) begin
        tmp = mags[j]; mags[j] = mags[j-1]; mags[j-1] = tmp;
      end
    acc = 0;
    for (int i = 0; i < vec_len; i++) begin
      acc += mags[i];
      prefix[i] = acc;
    end
    theta = 0;
    if (acc > radius) begin
      k = 0;
      for (int i = 0; i < vec_len; i++)
        if ($signed(mags[i]) * (i + 1) > prefix[i] - longint'(radius)) k = i;
      num = prefix[k] - longint'(radius);
      if (num > 0) theta = num / (k + 1);
    end
    for (int i = 0; i < vec_len; i++) begin
      v = vec_elems[i];
      if (v >= 0) begin
        p = v - theta;
        if (p < 0) p = 0;
      end else begin
        p = v + theta;
        if (p > 0) p = 0;
      end
      r.projected_value = p[31:0];
      r.result_last = (i == vec_len - 1);
      projection_queue.push_back(r);
    end
    vec_len = 0;
  endtask

  task automatic send_element(logic signed [31:0] value, logic last);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    in_data <= '{element_value: value, element_last: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    vec_elems[vec_len] = value;
    vec_len++;
    if (last || vec_len == MAX_LEN) predict_projection();
    @(posedge clk);
  endtask

  task automatic settle();
    while (projection_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_radius(logic [30:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    radius = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_element(int scale);
    case (scale)
      0: return $urandom;
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(32'h0000_0400)) - 32'sh200;
    endcase
  endfunction

  task automatic send_vector(int len, int scale);
    for (int i = 0; i < len; i++) send_element(rand_element(scale), i == len - 1);
  endtask

  task automatic test_directed();
    send_element(32'sh0000_4000, 1'b1);
    send_element(32'sh0001_0000, 1'b0);
    send_element(-32'sh0001_0000, 1'b1);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0000_0001, 1'b0);
    send_element(32'sh0000_0000, 1'b1);
    send_element(32'sh0003_0000, 1'b0);
    send_element(32'sh0003_0000, 1'b0);
    send_element(-32'sh0003_0000, 1'b1);
    set_radius('0);
    send_element(32'sh0002_0000, 1'b0);
    send_element(-32'sh0005_0000, 1'b1);
    send_element(32'sh8000_0000, 1'b1);
    set_radius(31'h7fff_ffff);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b1);
    send_element(32'sh1234_5678, 1'b1);
  endtask

  task automatic test_full_buffer();
    set_radius(31'h0004_0000);
    for (int i = 0; i < MAX_LEN; i++) send_element(rand_element(i % 3), 1'b0);
  endtask

  task automatic test_random(int pct, int items);
    int sent;
    int len;
    gap_pct = pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) set_radius(31'($urandom));
      else if ($urandom_range(9) == 0) set_radius(31'($urandom_range(31'h0008_0000)));
      len = ($urandom_range(15) == 0) ? $urandom_range(MAX_LEN, 2) : $urandom_range(6, 1);
      send_vector(len, $urandom_range(2));
      sent += len;
      if ($urandom_range(7) == 0) settle();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (projection_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data.projected_value !== projection_queue[0].projected_value ||
            out_data.result_last !== projection_queue[0].result_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", projection_queue[0], out_data);
        end
        void'(projection_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    vec_len = 0;
    gap_pct = 0;
    radius = 31'h0001_0000;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_buffer();
    test_random(0, 80);
    test_random(78, 80);
    test_random(8, 80);
    test_random(0, 80);
    settle();
    if (mismatches == 0 && projection_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
